FILE: hw/rtl/mmhq_pkg.sv
// ---------------------------------------------------------------------------
// mmhq_pkg
// Shared types, codes and helpers for the min-max heap queue.
// ---------------------------------------------------------------------------
`default_nettype none

package mmhq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP_MIN = 2'd1,
    CMD_POP_MAX = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // datapath micro-operations, one per cycle
  typedef enum logic [4:0] {
    OP_NOP         = 5'd0,
    OP_START       = 5'd1,
    OP_BU_RDP      = 5'd2,
    OP_BU_PCMP     = 5'd3,
    OP_CL_RDG      = 5'd4,
    OP_CL_CMP      = 5'd5,
    OP_WR_X        = 5'd6,
    OP_TOP_RD0     = 5'd7,
    OP_TOP_CMP     = 5'd8,
    OP_POP_SETMAX  = 5'd9,
    OP_POP_RDAT    = 5'd10,
    OP_POP_RDLAST  = 5'd11,
    OP_POP_TAKE    = 5'd12,
    OP_SK_RD0      = 5'd13,
    OP_SK_CMP      = 5'd14,
    OP_SK_DEC      = 5'd15,
    OP_SK_RDP      = 5'd16,
    OP_SK_PCMP     = 5'd17,
    OP_OUT         = 5'd18
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic idx_gt2;
    logic better_x_rd;
    logic top_next_ok;
    logic has_child;
    logic sk_next_ok;
    logic better_best_x;
    logic best_child;
  } dp_stat_t;

  // true when a belongs above b on a level of the given kind
  function automatic logic better(input logic is_min, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
    return is_min ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/min_max_heap_queue.sv
// ---------------------------------------------------------------------------
// min_max_heap_queue
// Double-ended priority queue of signed 32-bit values held as a min-max heap.
// ---------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       to block   in_valid_i / in_stall_o   command_i, push_value_i
// out      from block out_valid_o / out_stall_i popped_value_o, min_value_o,
//                                               max_value_o, entry_count_o, status_o
//
// one transaction at a time; the heap memory has one read and one write port
// every transaction ends with a read of the top three entries
// reset clears the count and the control state only; the memory needs no clearing pass
// a finished result waits in the output register while the next one is accepted
// ---------------------------------------------------------------------------
`default_nettype none

module min_max_heap_queue #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      popped_value_o,
  output logic signed [31:0]      min_value_o,
  output logic signed [31:0]      max_value_o,
  output logic [10:0]             entry_count_o,
  output logic [1:0]              status_o
);

  mmhq_pkg::dp_cmd_t  dp_cmd;
  mmhq_pkg::dp_stat_t dp_stat;

  mmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  mmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .dp_stat_o      (dp_stat),
    .command_i      (command_i),
    .push_value_i   (push_value_i),
    .popped_value_o (popped_value_o),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mmhq_ctrl.sv
// ---------------------------------------------------------------------------
// mmhq_ctrl
// Sequencer for push, pop and summary walks; drives the datapath one op a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mmhq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        command_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mmhq_pkg::dp_cmd_t      dp_cmd_o,
  input  wire mmhq_pkg::dp_stat_t dp_stat_i
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_BU_RDP  = 18'b000000000000000010,
    S_BU_PCMP = 18'b000000000000000100,
    S_CL_CHK  = 18'b000000000000001000,
    S_CL_CMP  = 18'b000000000000010000,
    S_WR_X    = 18'b000000000000100000,
    S_TOP_RD  = 18'b000000000001000000,
    S_TOP_CMP = 18'b000000000010000000,
    S_POP_MAX = 18'b000000000100000000,
    S_POP_A   = 18'b000000001000000000,
    S_POP_B   = 18'b000000010000000000,
    S_POP_C   = 18'b000000100000000000,
    S_SK_CHK  = 18'b000001000000000000,
    S_SK_CMP  = 18'b000010000000000000,
    S_SK_DEC  = 18'b000100000000000000,
    S_SK_RDP  = 18'b001000000000000000,
    S_SK_PCMP = 18'b010000000000000000,
    S_DONE    = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;
  logic   pre_q, pre_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    pre_d       = pre_q;
    out_valid_d = out_valid_q && out_stall_i;
    dp_cmd_o.op = mmhq_pkg::OP_NOP;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dp_cmd_o.op = mmhq_pkg::OP_START;
          state_d     = S_TOP_RD;
          pre_d       = 1'b0;
          if (command_i == mmhq_pkg::CMD_PUSH) begin
            if (!dp_stat_i.full) state_d = dp_stat_i.empty ? S_WR_X : S_BU_RDP;
          end else if (command_i == mmhq_pkg::CMD_POP_MIN) begin
            if (!dp_stat_i.empty) state_d = S_POP_A;
          end else if (command_i == mmhq_pkg::CMD_POP_MAX) begin
            if (!dp_stat_i.empty) pre_d = 1'b1;
          end
        end
      end
      S_BU_RDP: begin
        dp_cmd_o.op = mmhq_pkg::OP_BU_RDP;
        state_d     = S_BU_PCMP;
      end
      S_BU_PCMP: begin
        dp_cmd_o.op = mmhq_pkg::OP_BU_PCMP;
        state_d     = S_CL_CHK;
      end
      S_CL_CHK: begin
        dp_cmd_o.op = mmhq_pkg::OP_CL_RDG;
        state_d     = dp_stat_i.idx_gt2 ? S_CL_CMP : S_WR_X;
      end
      S_CL_CMP: begin
        dp_cmd_o.op = mmhq_pkg::OP_CL_CMP;
        state_d     = dp_stat_i.better_x_rd ? S_CL_CHK : S_WR_X;
      end
      S_WR_X: begin
        dp_cmd_o.op = mmhq_pkg::OP_WR_X;
        state_d     = S_TOP_RD;
        pre_d       = 1'b0;
      end
      S_TOP_RD: begin
        dp_cmd_o.op = mmhq_pkg::OP_TOP_RD0;
        state_d     = dp_stat_i.empty ? S_DONE : S_TOP_CMP;
      end
      S_TOP_CMP: begin
        dp_cmd_o.op = mmhq_pkg::OP_TOP_CMP;
        if (!dp_stat_i.top_next_ok) state_d = pre_q ? S_POP_MAX : S_DONE;
      end
      S_POP_MAX: begin
        dp_cmd_o.op = mmhq_pkg::OP_POP_SETMAX;
        pre_d       = 1'b0;
        state_d     = S_POP_A;
      end
      S_POP_A: begin
        dp_cmd_o.op = mmhq_pkg::OP_POP_RDAT;
        state_d     = S_POP_B;
      end
      S_POP_B: begin
        dp_cmd_o.op = mmhq_pkg::OP_POP_RDLAST;
        state_d     = S_POP_C;
      end
      S_POP_C: begin
        dp_cmd_o.op = mmhq_pkg::OP_POP_TAKE;
        state_d     = S_SK_CHK;
      end
      S_SK_CHK: begin
        dp_cmd_o.op = mmhq_pkg::OP_SK_RD0;
        state_d     = dp_stat_i.has_child ? S_SK_CMP : S_WR_X;
      end
      S_SK_CMP: begin
        dp_cmd_o.op = mmhq_pkg::OP_SK_CMP;
        if (!dp_stat_i.sk_next_ok) state_d = S_SK_DEC;
      end
      S_SK_DEC: begin
        dp_cmd_o.op = mmhq_pkg::OP_SK_DEC;
        // a grandchild swap may still need fixing against its parent
        state_d     = (dp_stat_i.better_best_x && !dp_stat_i.best_child) ? S_SK_RDP : S_WR_X;
      end
      S_SK_RDP: begin
        dp_cmd_o.op = mmhq_pkg::OP_SK_RDP;
        state_d     = S_SK_PCMP;
      end
      S_SK_PCMP: begin
        dp_cmd_o.op = mmhq_pkg::OP_SK_PCMP;
        state_d     = S_SK_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          dp_cmd_o.op = mmhq_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pre_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pre_q       <= pre_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mmhq_datapath.sv
// ---------------------------------------------------------------------------
// mmhq_datapath
// Heap memory, moving value, index and compare registers, result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module mmhq_datapath #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mmhq_pkg::dp_cmd_t  dp_cmd_i,
  output mmhq_pkg::dp_stat_t      dp_stat_o,
  input  wire logic [1:0]         command_i,
  input  wire logic signed [31:0] push_value_i,
  output logic signed [31:0]      popped_value_o,
  output logic signed [31:0]      min_value_o,
  output logic signed [31:0]      max_value_o,
  output logic [10:0]             entry_count_o,
  output logic [1:0]              status_o
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int AW   = IW + 3;

  function automatic logic lvl_min(input logic [IW:0] n);
    logic odd;
    odd = 1'b0;
    for (int b = 0; b <= IW; b++) begin
      if (n[b]) odd = b[0];
    end
    return !odd;
  endfunction

  // children then grandchildren of i, in index order
  function automatic logic [AW-1:0] cand(input logic [IW-1:0] i, input logic [2:0] k);
    logic [AW-1:0] ie;
    ie = AW'(i);
    case (k)
      3'd0:    return (ie << 1) + AW'(1);
      3'd1:    return (ie << 1) + AW'(2);
      default: return (ie << 2) + AW'(1) + AW'(k);
    endcase
  endfunction

  logic signed [31:0] mem [CAPACITY];
  logic               mem_we;
  logic [IW-1:0]      mem_wa, mem_ra;
  logic signed [31:0] mem_wd;
  logic signed [31:0] rd_q;

  logic signed [31:0] x_q, x_d, best_q, best_d, popped_q, popped_d;
  logic signed [31:0] min_q, min_d, max_q, max_d;
  logic [IW-1:0]      i_q, i_d, best_idx_q, best_idx_d;
  logic [2:0]         k_q, k_d, best_k_q, best_k_d;
  logic [1:0]         j_q, j_d, midx_q, midx_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic               is_min_q, is_min_d;
  logic [1:0]         status_q, status_d;

  logic signed [31:0] o_pop_q, o_min_q, o_max_q;
  logic [10:0]        o_cnt_q;
  logic [1:0]         o_st_q;

  logic [IW-1:0]      par_i, gp_i;
  logic [IW:0]        i_ext;
  logic [AW-1:0]      cand_cur, cand_nxt, cnt_w;
  logic [2:0]         k_nxt;

  assign i_ext    = {1'b0, i_q} + (IW+1)'(1);
  assign par_i    = IW'((i_q - IW'(1)) >> 1);
  assign gp_i     = IW'((i_ext >> 2) - (IW+1)'(1));
  assign k_nxt    = k_q + 3'd1;
  assign cand_cur = cand(i_q, k_q);
  assign cand_nxt = cand(i_q, k_nxt);
  assign cnt_w    = AW'(cnt_q);

  assign dp_stat_o.empty         = (cnt_q == '0);
  assign dp_stat_o.full          = (cnt_q == CNTW'(CAPACITY));
  assign dp_stat_o.idx_gt2       = (i_q > IW'(2));
  assign dp_stat_o.better_x_rd   = mmhq_pkg::better(is_min_q, x_q, rd_q);
  assign dp_stat_o.top_next_ok   = (j_q < 2'd2) && ((CNTW'(j_q) + CNTW'(1)) < cnt_q);
  assign dp_stat_o.has_child     = (cand(i_q, 3'd0) < cnt_w);
  assign dp_stat_o.sk_next_ok    = (k_q < 3'd5) && (cand_nxt < cnt_w);
  assign dp_stat_o.better_best_x = mmhq_pkg::better(is_min_q, best_q, x_q);
  assign dp_stat_o.best_child    = (best_k_q < 3'd2);

  always_comb begin
    x_d        = x_q;
    best_d     = best_q;
    popped_d   = popped_q;
    min_d      = min_q;
    max_d      = max_q;
    i_d        = i_q;
    best_idx_d = best_idx_q;
    k_d        = k_q;
    best_k_d   = best_k_q;
    j_d        = j_q;
    midx_d     = midx_q;
    cnt_d      = cnt_q;
    is_min_d   = is_min_q;
    status_d   = status_q;
    mem_we     = 1'b0;
    mem_wa     = i_q;
    mem_wd     = x_q;
    mem_ra     = i_q;
    case (dp_cmd_i.op)
      mmhq_pkg::OP_START: begin
        x_d      = push_value_i;
        popped_d = '0;
        status_d = mmhq_pkg::ST_OK;
        if (command_i == mmhq_pkg::CMD_PUSH) begin
          if (dp_stat_o.full) begin
            status_d = mmhq_pkg::ST_FULL;
          end else begin
            i_d      = IW'(cnt_q);
            cnt_d    = cnt_q + CNTW'(1);
            is_min_d = lvl_min((IW+1)'(cnt_q) + (IW+1)'(1));
          end
        end else if (command_i == mmhq_pkg::CMD_POP_MIN ||
                     command_i == mmhq_pkg::CMD_POP_MAX) begin
          if (dp_stat_o.empty) status_d = mmhq_pkg::ST_EMPTY;
          i_d = '0;
        end
      end
      mmhq_pkg::OP_BU_RDP: begin
        mem_ra = par_i;
      end
      mmhq_pkg::OP_BU_PCMP: begin
        if (mmhq_pkg::better(is_min_q, rd_q, x_q)) begin
          mem_we   = 1'b1;
          mem_wd   = rd_q;
          i_d      = par_i;
          is_min_d = !is_min_q;
        end
      end
      mmhq_pkg::OP_CL_RDG: begin
        mem_ra = gp_i;
      end
      mmhq_pkg::OP_CL_CMP: begin
        if (dp_stat_o.better_x_rd) begin
          mem_we = 1'b1;
          mem_wd = rd_q;
          i_d    = gp_i;
        end
      end
      mmhq_pkg::OP_WR_X: begin
        mem_we = 1'b1;
      end
      mmhq_pkg::OP_TOP_RD0: begin
        mem_ra = '0;
        j_d    = '0;
        if (dp_stat_o.empty) begin
          min_d = '0;
          max_d = '0;
        end
      end
      mmhq_pkg::OP_TOP_CMP: begin
        if (j_q == 2'd0) begin
          min_d  = rd_q;
          max_d  = rd_q;
          midx_d = '0;
        end else if (max_q < rd_q) begin
          max_d  = rd_q;
          midx_d = j_q;
        end
        if (dp_stat_o.top_next_ok) begin
          mem_ra = IW'(j_q) + IW'(1);
          j_d    = j_q + 2'd1;
        end
      end
      mmhq_pkg::OP_POP_SETMAX: begin
        i_d = IW'(midx_q);
      end
      mmhq_pkg::OP_POP_RDAT: begin
        mem_ra = i_q;
      end
      mmhq_pkg::OP_POP_RDLAST: begin
        popped_d = rd_q;
        mem_ra   = IW'(cnt_q - CNTW'(1));
      end
      mmhq_pkg::OP_POP_TAKE: begin
        x_d      = rd_q;
        cnt_d    = cnt_q - CNTW'(1);
        is_min_d = lvl_min(i_ext);
      end
      mmhq_pkg::OP_SK_RD0: begin
        mem_ra = IW'(cand(i_q, 3'd0));
        k_d    = '0;
      end
      mmhq_pkg::OP_SK_CMP: begin
        if (k_q == 3'd0 || mmhq_pkg::better(is_min_q, rd_q, best_q)) begin
          best_d     = rd_q;
          best_idx_d = IW'(cand_cur);
          best_k_d   = k_q;
        end
        if (dp_stat_o.sk_next_ok) begin
          mem_ra = IW'(cand_nxt);
          k_d    = k_nxt;
        end
      end
      mmhq_pkg::OP_SK_DEC: begin
        if (dp_stat_o.better_best_x) begin
          mem_we = 1'b1;
          mem_wd = best_q;
          i_d    = best_idx_q;
        end
      end
      mmhq_pkg::OP_SK_RDP: begin
        mem_ra = par_i;
      end
      mmhq_pkg::OP_SK_PCMP: begin
        // moving value settles in the parent, the parent's value moves on
        if (mmhq_pkg::better(is_min_q, rd_q, x_q)) begin
          mem_we = 1'b1;
          mem_wa = par_i;
          x_d    = rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    best_q     <= best_d;
    popped_q   <= popped_d;
    min_q      <= min_d;
    max_q      <= max_d;
    i_q        <= i_d;
    best_idx_q <= best_idx_d;
    k_q        <= k_d;
    best_k_q   <= best_k_d;
    j_q        <= j_d;
    midx_q     <= midx_d;
    is_min_q   <= is_min_d;
    status_q   <= status_d;
    if (dp_cmd_i.op == mmhq_pkg::OP_OUT) begin
      o_pop_q <= popped_q;
      o_min_q <= min_q;
      o_max_q <= max_q;
      o_cnt_q <= 11'(cnt_q);
      o_st_q  <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign popped_value_o = o_pop_q;
  assign min_value_o    = o_min_q;
  assign max_value_o    = o_max_q;
  assign entry_count_o  = o_cnt_q;
  assign status_o       = o_st_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mmhq_checker.sv
// ---------------------------------------------------------------------------
// mmhq_checker
// Port-level checks on the min-max heap queue results.
// ---------------------------------------------------------------------------
`default_nettype none

module mmhq_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] popped_value_o,
  input wire logic signed [31:0] min_value_o,
  input wire logic signed [31:0] max_value_o,
  input wire logic [10:0]        entry_count_o,
  input wire logic [1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_value_o))
    else $error("result dropped while stalled");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_value_o <= max_value_o)
    else $error("minimum above maximum");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_count_o == 11'd0 |-> min_value_o == 0 && max_value_o == 0)
    else $error("empty queue reports values");

  a_refused_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mmhq_pkg::ST_OK |-> popped_value_o == 0)
    else $error("refused transaction returns a value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mmhq_pkg::ST_EMPTY |-> entry_count_o == 11'd0)
    else $error("empty refusal with entries stored");

endmodule

bind min_max_heap_queue mmhq_checker u_mmhq_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_min_max_heap_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_min_max_heap_queue
// Self-checking bench for the min-max heap queue: a directed table of
// commands followed by random mixed, fill-to-full and partial drain phases,
// with each result checked against a bench-side behavioural heap or a fixed row.
// ---------------------------------------------------------------------------

module tb_min_max_heap_queue;

  localparam int CAPACITY = 1024;

  typedef struct {
    int                 popped;
    int                 min_v;
    int                 max_v;
    logic [10:0]        count;
    mmhq_pkg::status_e  st;
  } heap_result_t;

  typedef struct {
    mmhq_pkg::cmd_e     cmd;
    int                 value;
    bit                 fixed;
    heap_result_t       res;
  } heap_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        command_i;
  logic signed [31:0] push_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [31:0] popped_value_o;
  logic signed [31:0] min_value_o;
  logic signed [31:0] max_value_o;
  logic [10:0]       entry_count_o;
  logic [1:0]        status_o;

  min_max_heap_queue #(.CAPACITY(CAPACITY)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .push_value_i,
    .out_valid_o, .out_stall_i, .popped_value_o, .min_value_o, .max_value_o,
    .entry_count_o, .status_o
  );

  // shadow heap
  int            heap_mem [CAPACITY];
  int            heap_cnt;
  heap_result_t  expected_q [$];
  int            n_errors;
  int            n_checked;
  int            n_push, n_pop, n_full, n_empty;
  bit            quiet;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic bit on_min_row(int i);
    int n;
    int d;
    n = i + 1;
    d = 0;
    while (n > 1) begin
      n = n >> 1;
      d++;
    end
    return (d % 2) == 0;
  endfunction

  function automatic bit ranks_above(bit is_min, int a, int b);
    return is_min ? (a < b) : (a > b);
  endfunction

  function automatic void swap_entries(int a, int b);
    int t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void climb(int i, bit is_min);
    int g;
    while (i > 2) begin
      g = ((i + 1) >> 2) - 1;
      if (!ranks_above(is_min, heap_mem[i], heap_mem[g])) break;
      swap_entries(i, g);
      i = g;
    end
  endfunction

  function automatic void sift_up(int i);
    int p;
    bit is_min;
    if (i == 0) return;
    p = ((i + 1) >> 1) - 1;
    is_min = on_min_row(i);
    if (ranks_above(is_min, heap_mem[p], heap_mem[i])) begin
      swap_entries(p, i);
      climb(p, !is_min);
    end else begin
      climb(i, is_min);
    end
  endfunction

  // extreme among children and grandchildren, first in index order on ties
  function automatic int extreme_below(int i, bit is_min);
    int best;
    int cand [5];
    best = 2 * i + 1;
    cand[0] = 2 * i + 2;
    for (int k = 1; k < 5; k++) cand[k] = 4 * i + 2 + k;
    for (int k = 0; k < 5; k++) begin
      if (cand[k] >= heap_cnt) break;
      if (ranks_above(is_min, heap_mem[cand[k]], heap_mem[best])) best = cand[k];
    end
    return best;
  endfunction

  function automatic void sift_down(int i);
    bit is_min;
    int m;
    int mp;
    is_min = on_min_row(i);
    while (2 * i + 1 < heap_cnt) begin
      m = extreme_below(i, is_min);
      if (!ranks_above(is_min, heap_mem[m], heap_mem[i])) return;
      swap_entries(m, i);
      if (m <= 2 * i + 2) return;
      mp = ((m + 1) >> 1) - 1;
      if (ranks_above(is_min, heap_mem[mp], heap_mem[m])) swap_entries(mp, m);
      i = m;
    end
  endfunction

  function automatic int max_slot();
    int best;
    best = 0;
    for (int i = 1; i <= 2 && i < heap_cnt; i++)
      if (heap_mem[best] < heap_mem[i]) best = i;
    return best;
  endfunction

  function automatic heap_result_t apply_command(mmhq_pkg::cmd_e c, int v);
    heap_result_t r;
    int at;
    r.popped = 0;
    r.st = mmhq_pkg::ST_OK;
    case (c)
      mmhq_pkg::CMD_PUSH: begin
        if (heap_cnt >= CAPACITY) begin
          r.st = mmhq_pkg::ST_FULL;
          n_full++;
        end else begin
          heap_mem[heap_cnt] = v;
          heap_cnt++;
          sift_up(heap_cnt - 1);
          n_push++;
        end
      end
      mmhq_pkg::CMD_POP_MIN, mmhq_pkg::CMD_POP_MAX: begin
        if (heap_cnt == 0) begin
          r.st = mmhq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          at = (c == mmhq_pkg::CMD_POP_MIN) ? 0 : max_slot();
          r.popped = heap_mem[at];
          heap_mem[at] = heap_mem[heap_cnt - 1];
          heap_cnt--;
          sift_down(at);
          n_pop++;
        end
      end
      default: ;
    endcase
    r.min_v = heap_cnt ? heap_mem[0] : 0;
    r.max_v = heap_cnt ? heap_mem[max_slot()] : 0;
    r.count = heap_cnt[10:0];
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_command(mmhq_pkg::cmd_e c, int v, bit fixed, heap_result_t fr);
    heap_result_t r;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    command_i    = c;
    push_value_i = v;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    r = apply_command(c, v);
    expected_q.insert(expected_q.size(), fixed ? fr : r);
    @(negedge clk_i);
  endtask

  function automatic int random_value();
    // narrow values give plenty of ties
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 15) - 8;
    return $urandom;
  endfunction

  function automatic mmhq_pkg::cmd_e random_cmd(int push_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < push_pct) return mmhq_pkg::CMD_PUSH;
    if (p < push_pct + (100 - push_pct) * 4 / 10) return mmhq_pkg::CMD_POP_MIN;
    if (p < push_pct + (100 - push_pct) * 8 / 10) return mmhq_pkg::CMD_POP_MAX;
    return mmhq_pkg::CMD_QUERY;
  endfunction

  // consumer side
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= !quiet && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk_i) begin
    heap_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction popped=%0d", $time, popped_value_o);
        n_errors++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        n_checked++;
        if (popped_value_o !== e.popped) begin
          $display("%0t: popped_value exp %0d got %0d", $time, e.popped, popped_value_o);
          n_errors++;
        end
        if (min_value_o !== e.min_v) begin
          $display("%0t: min_value exp %0d got %0d", $time, e.min_v, min_value_o);
          n_errors++;
        end
        if (max_value_o !== e.max_v) begin
          $display("%0t: max_value exp %0d got %0d", $time, e.max_v, max_value_o);
          n_errors++;
        end
        if (entry_count_o !== e.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.count, entry_count_o);
          n_errors++;
        end
        if (status_o !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  heap_row_t    rows [$];
  heap_result_t none;

  function automatic heap_result_t res(int p, int mn, int mx, int n, mmhq_pkg::status_e s);
    heap_result_t r;
    r.popped = p;
    r.min_v = mn;
    r.max_v = mx;
    r.count = n[10:0];
    r.st = s;
    return r;
  endfunction

  function automatic heap_row_t row(mmhq_pkg::cmd_e c, int v, bit f, heap_result_t r);
    heap_row_t x;
    x.cmd = c;
    x.value = v;
    x.fixed = f;
    x.res = r;
    return x;
  endfunction

  initial begin
    int vals [10];
    int n_fill;
    heap_result_t empty_r;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = mmhq_pkg::CMD_QUERY;
    push_value_i = '0;
    quiet        = 1'b0;
    heap_cnt     = 0;
    n_errors     = 0;
    n_checked    = 0;
    n_fill       = 0;
    n_push = 0; n_pop = 0; n_full = 0; n_empty = 0;
    none = res(0, 0, 0, 0, mmhq_pkg::ST_OK);
    empty_r = res(0, 0, 0, 0, mmhq_pkg::ST_EMPTY);

    // directed table: empty store, extremes, ties, then drain past empty
    rows.insert(rows.size(), row(mmhq_pkg::CMD_POP_MIN, 0, 1, empty_r));
    rows.insert(rows.size(), row(mmhq_pkg::CMD_POP_MAX, 0, 1, empty_r));
    rows.insert(rows.size(), row(mmhq_pkg::CMD_QUERY, 0, 1, none));
    rows.insert(rows.size(), row(mmhq_pkg::CMD_PUSH, 32'h7fffffff, 1,
                res(0, 32'h7fffffff, 32'h7fffffff, 1, mmhq_pkg::ST_OK)));
    rows.insert(rows.size(), row(mmhq_pkg::CMD_PUSH, 32'h80000000, 1,
                res(0, 32'h80000000, 32'h7fffffff, 2, mmhq_pkg::ST_OK)));
    vals = '{0, -1, 1, 5, 5, -7, 32'h55555555, 32'haaaaaaaa, 3, -1};
    foreach (vals[i]) rows.insert(rows.size(), row(mmhq_pkg::CMD_PUSH, vals[i], 0, none));
    rows.insert(rows.size(), row(mmhq_pkg::CMD_QUERY, 0, 0, none));
    for (int i = 0; i < 6; i++)
      rows.insert(rows.size(), row(mmhq_pkg::CMD_POP_MAX, 0, 0, none));
    for (int i = 0; i < 6; i++)
      rows.insert(rows.size(), row(mmhq_pkg::CMD_POP_MIN, 0, 0, none));
    rows.insert(rows.size(), row(mmhq_pkg::CMD_POP_MIN, 0, 1, empty_r));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_command(rows[i].cmd, rows[i].value, rows[i].fixed, rows[i].res);

    // mixed traffic
    for (int i = 0; i < 100; i++) begin
      send_command(random_cmd(55), random_value(), 0, none);
    end

    // hold off until the block has answered everything
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);

    // fill to capacity, the first stretch with no idling on either side
    while (heap_cnt < CAPACITY) begin
      quiet = (n_fill < 300);
      send_command(random_cmd(97), random_value(), 0, none);
      n_fill++;
    end
    quiet = 1'b0;
    for (int i = 0; i < 4; i++) send_command(mmhq_pkg::CMD_PUSH, random_value(), 0, none);
    send_command(mmhq_pkg::CMD_QUERY, 0, 0, none);

    // pop-heavy tail from a full store
    for (int i = 0; i < 60; i++) send_command(random_cmd(8), random_value(), 0, none);
    in_valid_i = 1'b0;

    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);

    $display("checked %0d result transactions: %0d pushes, %0d pops", n_checked, n_push,
             n_pop);
    $display("refused: %0d pushes into a full store, %0d pops from an empty one", n_full,
             n_empty);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
